// ===== rtl/prf_pkg.sv =====
`timescale 1ns / 1ps

package prf_pkg;

   // Widths of the item fields
   localparam int BYTE_W  = 8;
   localparam int FLEN_W  = 12;
   localparam int TIME_W  = 32;
   localparam int CHAN_W  = 8;
   localparam int SNAP_W  = 9;
   localparam int FREQ_W  = 12;
   localparam int SEC_W   = 13;
   localparam int USEC_W  = 20;
   localparam int BIDX_W  = 12;

   // Capture limits and record layout
   localparam int MAX_SNAP  = 256;
   localparam int RTAP_LEN  = 15;
   localparam int HDR_LEN   = 31;
   localparam int HIDX_W    = $clog2(HDR_LEN + 1);
   localparam int US_PER_S  = 1000000;

   // Seconds = (t >> DIV_SHIFT) / 15625, via reciprocal DIV_RECIP / 2^DIV_RSH
   localparam int DIV_SHIFT = 6;
   localparam int DIV_RSH   = 40;
   localparam longint DIV_RECIP = 64'd70368744;
   localparam int RECIP_W   = 27;
   localparam int DIVX_W    = TIME_W - DIV_SHIFT;
   localparam int PROD_W    = DIVX_W + RECIP_W;

   // Frequency mapping
   localparam int FREQ_CH14 = 2484;
   localparam int FREQ_BASE = 2412;
   localparam int FREQ_STEP = 5;
   localparam int CHAN_MIN  = 1;
   localparam int CHAN_MAX  = 14;

   // Command queue between front and back
   localparam int Q_DEPTH = 8;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = Q_PTR_W + 1;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPTURE_ENABLE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_SNAP_LENGTH    = CSR_INDEX_W'(1);

   typedef struct packed {
      logic [BYTE_W-1:0]        frame_byte;
      logic                     first_of_frame;
      logic [FLEN_W-1:0]        frame_length;
      logic [TIME_W-1:0]        time_us;
      logic signed [BYTE_W-1:0] signal_dbm;
      logic [CHAN_W-1:0]        channel_number;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              record_last;
   } rsp_type;

   // One classified item in flight through the divider pipeline
   typedef struct packed {
      logic              hdr;
      logic              pl;
      logic              last;
      logic [BYTE_W-1:0] data;
      logic [SNAP_W-1:0] kept;
      logic [FLEN_W-1:0] flen;
      logic [BYTE_W-1:0] sig;
      logic [FREQ_W-1:0] freq;
      logic [TIME_W-1:0] time_us;
   } pipe_type;

   // One queue entry: a header (optional payload byte) or a lone payload byte
   typedef struct packed {
      logic              hdr;
      logic              pl;
      logic              last;
      logic [BYTE_W-1:0] data;
      logic [SNAP_W-1:0] kept;
      logic [FLEN_W-1:0] flen;
      logic [BYTE_W-1:0] sig;
      logic [FREQ_W-1:0] freq;
      logic [SEC_W-1:0]  sec;
      logic [USEC_W-1:0] usec;
   } cmd_type;

   typedef struct packed {
      logic               empty;
      logic [Q_CNT_W-1:0] count;
   } q_stat_type;

endpackage

// ===== rtl/prf_front.sv =====
`timescale 1ns / 1ps

module prf_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  prf_pkg::req_type                     req_word,
   input  logic                                 csr_valid,
   input  logic [prf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [prf_pkg::SNAP_W-1:0]           csr_wdata,
   input  prf_pkg::q_stat_type                  q_stat,
   output logic                                 cmd_push,
   output prf_pkg::cmd_type                     cmd_word
);

   logic                        cap_en_ff;
   logic [prf_pkg::SNAP_W-1:0]  snap_ff;
   logic [prf_pkg::BIDX_W-1:0]  byte_index_ff, byte_index_in;
   logic [prf_pkg::SNAP_W-1:0]  kept_ff, kept_in;
   logic                        in_rec_ff, in_rec_in;

   logic                        accept;
   logic [prf_pkg::SNAP_W-1:0]  snap_sat, kept_new, cur_kept;
   logic [prf_pkg::BIDX_W-1:0]  cur_bi;
   logic                        c_valid, c_hdr, c_pl, c_last;
   logic [3:0]                  chan_c;
   logic [prf_pkg::FREQ_W-1:0]  freq;

   logic                                v1_ff, v2_ff, v3_ff;
   prf_pkg::pipe_type                   p1_in, p1_ff, p2_ff, p3_ff;
   logic [prf_pkg::PROD_W-1:0]          prod_ff;
   logic [prf_pkg::SEC_W-1:0]           qest_ff;
   logic [prf_pkg::TIME_W-1:0]          qm_ff;
   logic [prf_pkg::TIME_W-1:0]          rem;
   logic                                fix;
   logic [prf_pkg::Q_CNT_W+1:0]         pending;

   // Everything in flight must fit in the queue
   assign pending = (prf_pkg::Q_CNT_W+2)'(q_stat.count) + (prf_pkg::Q_CNT_W+2)'(v1_ff)
                  + (prf_pkg::Q_CNT_W+2)'(v2_ff) + (prf_pkg::Q_CNT_W+2)'(v3_ff);
   assign full   = pending >= (prf_pkg::Q_CNT_W+2)'(prf_pkg::Q_DEPTH);
   assign accept = push && !full;

   always_comb begin
      if (32'(snap_ff) > 32'(prf_pkg::MAX_SNAP)) begin
         snap_sat = prf_pkg::SNAP_W'(prf_pkg::MAX_SNAP);
      end else begin
         snap_sat = snap_ff;
      end
      if (req_word.frame_length < prf_pkg::FLEN_W'(snap_sat)) begin
         kept_new = prf_pkg::SNAP_W'(req_word.frame_length);
      end else begin
         kept_new = snap_sat;
      end
   end

   // Classify the item and advance the record state
   always_comb begin
      byte_index_in = byte_index_ff;
      kept_in       = kept_ff;
      in_rec_in     = in_rec_ff;
      c_valid       = 1'b0;
      c_hdr         = 1'b0;
      c_pl          = 1'b0;
      c_last        = 1'b0;
      cur_bi        = req_word.first_of_frame ? '0 : byte_index_ff;
      cur_kept      = req_word.first_of_frame ? kept_new : kept_ff;
      if (accept && !cap_en_ff) begin
         in_rec_in = 1'b0;
      end else if (accept && req_word.first_of_frame && kept_new == '0) begin
         c_valid       = 1'b1;
         c_hdr         = 1'b1;
         c_last        = 1'b0;
         kept_in       = kept_new;
         byte_index_in = '0;
         in_rec_in     = 1'b0;
      end else if (accept && (req_word.first_of_frame || in_rec_ff)) begin
         c_valid   = req_word.first_of_frame;
         c_hdr     = req_word.first_of_frame;
         kept_in   = cur_kept;
         in_rec_in = 1'b1;
         if (prf_pkg::BIDX_W'(cur_kept) > cur_bi) begin
            c_valid = 1'b1;
            c_pl    = 1'b1;
            c_last  = (cur_bi + 1'b1) == prf_pkg::BIDX_W'(cur_kept);
            if (c_last) begin
               in_rec_in = 1'b0;
            end
         end
         byte_index_in = (cur_bi == '1) ? cur_bi : cur_bi + 1'b1;
      end
   end

   // Clamp the channel and map it to a 2 GHz frequency
   always_comb begin
      if (req_word.channel_number < prf_pkg::CHAN_W'(prf_pkg::CHAN_MIN)) begin
         chan_c = 4'(prf_pkg::CHAN_MIN);
      end else if (req_word.channel_number > prf_pkg::CHAN_W'(prf_pkg::CHAN_MAX)) begin
         chan_c = 4'(prf_pkg::CHAN_MAX);
      end else begin
         chan_c = req_word.channel_number[3:0];
      end
      if (chan_c == 4'(prf_pkg::CHAN_MAX)) begin
         freq = prf_pkg::FREQ_W'(prf_pkg::FREQ_CH14);
      end else begin
         freq = prf_pkg::FREQ_W'(prf_pkg::FREQ_BASE)
              + prf_pkg::FREQ_W'(chan_c - 4'd1) * prf_pkg::FREQ_W'(prf_pkg::FREQ_STEP);
      end
   end

   always_comb begin
      p1_in.hdr     = c_hdr;
      p1_in.pl      = c_pl;
      p1_in.last    = c_last;
      p1_in.data    = req_word.frame_byte;
      p1_in.kept    = kept_new;
      p1_in.flen    = req_word.frame_length;
      p1_in.sig     = req_word.signal_dbm;
      p1_in.freq    = freq;
      p1_in.time_us = req_word.time_us;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_en_ff     <= 1'b0;
         snap_ff       <= prf_pkg::SNAP_W'(prf_pkg::MAX_SNAP);
         byte_index_ff <= '0;
         kept_ff       <= '0;
         in_rec_ff     <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               prf_pkg::CSR_CAPTURE_ENABLE: cap_en_ff <= csr_wdata[0];
               prf_pkg::CSR_SNAP_LENGTH:    snap_ff   <= csr_wdata;
               default: ;
            endcase
         end
         byte_index_ff <= byte_index_in;
         kept_ff       <= kept_in;
         in_rec_ff     <= in_rec_in;
         v1_ff         <= c_valid;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
      end
   end

   // Seconds by reciprocal multiply, then one correction step
   always_ff @(posedge clock) begin
      p1_ff   <= p1_in;
      p2_ff   <= p1_ff;
      prod_ff <= prf_pkg::PROD_W'(p1_ff.time_us[prf_pkg::TIME_W-1:prf_pkg::DIV_SHIFT])
               * prf_pkg::PROD_W'(prf_pkg::DIV_RECIP);
      p3_ff   <= p2_ff;
      qest_ff <= prod_ff[prf_pkg::PROD_W-1:prf_pkg::DIV_RSH];
      qm_ff   <= prf_pkg::TIME_W'(prod_ff[prf_pkg::PROD_W-1:prf_pkg::DIV_RSH]
               * prf_pkg::USEC_W'(prf_pkg::US_PER_S));
   end

   assign rem = p3_ff.time_us - qm_ff;
   assign fix = rem >= prf_pkg::TIME_W'(prf_pkg::US_PER_S);

   always_comb begin
      cmd_push      = v3_ff;
      cmd_word.hdr  = p3_ff.hdr;
      cmd_word.pl   = p3_ff.pl;
      cmd_word.last = p3_ff.last;
      cmd_word.data = p3_ff.data;
      cmd_word.kept = p3_ff.kept;
      cmd_word.flen = p3_ff.flen;
      cmd_word.sig  = p3_ff.sig;
      cmd_word.freq = p3_ff.freq;
      cmd_word.sec  = qest_ff + prf_pkg::SEC_W'(fix);
      cmd_word.usec = fix ? prf_pkg::USEC_W'(rem - prf_pkg::TIME_W'(prf_pkg::US_PER_S))
                          : prf_pkg::USEC_W'(rem);
   end

endmodule

// ===== rtl/prf_queue.sv =====
`timescale 1ns / 1ps

module prf_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  prf_pkg::cmd_type     wr_word,
   input  logic                 rd_en,
   output prf_pkg::cmd_type     rd_word,
   output prf_pkg::q_stat_type  q_stat
);

   prf_pkg::cmd_type              slot_ff [prf_pkg::Q_DEPTH];
   logic [prf_pkg::Q_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [prf_pkg::Q_CNT_W-1:0]   count_ff;

   assign rd_word      = slot_ff[rd_ptr_ff];
   assign q_stat.empty = count_ff == '0;
   assign q_stat.count = count_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + prf_pkg::Q_CNT_W'(wr_en) - prf_pkg::Q_CNT_W'(rd_en);
      end
   end

endmodule

// ===== rtl/prf_back.sv =====
`timescale 1ns / 1ps

module prf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  prf_pkg::cmd_type     head,
   input  prf_pkg::q_stat_type  q_stat,
   output logic                 deq,
   output logic                 empty,
   input  logic                 pop,
   output prf_pkg::rsp_type     rsp_word
);

   logic [prf_pkg::HIDX_W-1:0]  idx_ff, idx_in;
   logic                        out_v_ff;
   prf_pkg::rsp_type            out_ff, out_in;
   logic                        load, in_hdr, done, hdr_end;
   logic [15:0]                 cap_len, wire_len;
   logic [prf_pkg::TIME_W-1:0]  sec32, usec32;
   logic [prf_pkg::BYTE_W-1:0]  hdr_byte;

   assign cap_len  = 16'(prf_pkg::RTAP_LEN) + 16'(head.kept);
   assign wire_len = 16'(prf_pkg::RTAP_LEN) + 16'(head.flen);
   assign sec32    = prf_pkg::TIME_W'(head.sec);
   assign usec32   = prf_pkg::TIME_W'(head.usec);

   // Record header and radiotap header, little-endian
   always_comb begin
      unique case (idx_ff)
         5'd0:    hdr_byte = sec32[7:0];
         5'd1:    hdr_byte = sec32[15:8];
         5'd2:    hdr_byte = sec32[23:16];
         5'd3:    hdr_byte = sec32[31:24];
         5'd4:    hdr_byte = usec32[7:0];
         5'd5:    hdr_byte = usec32[15:8];
         5'd6:    hdr_byte = usec32[23:16];
         5'd7:    hdr_byte = usec32[31:24];
         5'd8:    hdr_byte = cap_len[7:0];
         5'd9:    hdr_byte = cap_len[15:8];
         5'd12:   hdr_byte = wire_len[7:0];
         5'd13:   hdr_byte = wire_len[15:8];
         5'd18:   hdr_byte = 8'(prf_pkg::RTAP_LEN);
         5'd20:   hdr_byte = 8'h2a;
         5'd24:   hdr_byte = 8'h10;
         5'd26:   hdr_byte = head.freq[7:0];
         5'd27:   hdr_byte = 8'(head.freq[prf_pkg::FREQ_W-1:8]);
         5'd28:   hdr_byte = 8'ha0;
         5'd30:   hdr_byte = head.sig;
         default: hdr_byte = 8'h00;
      endcase
   end

   assign load    = !q_stat.empty && (!out_v_ff || pop);
   assign in_hdr  = head.hdr && idx_ff != prf_pkg::HIDX_W'(prf_pkg::HDR_LEN);
   assign hdr_end = idx_ff == prf_pkg::HIDX_W'(prf_pkg::HDR_LEN - 1);

   always_comb begin
      if (in_hdr) begin
         out_in.out_byte    = hdr_byte;
         out_in.record_last = hdr_end && !head.pl;
         done               = hdr_end && !head.pl;
      end else begin
         out_in.out_byte    = head.data;
         out_in.record_last = head.last;
         done               = 1'b1;
      end
      idx_in = idx_ff;
      if (load) begin
         idx_in = done ? '0 : idx_ff + 1'b1;
      end
   end

   assign deq      = load && done;
   assign empty    = !out_v_ff;
   assign rsp_word = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         out_v_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         out_v_ff <= load || (out_v_ff && !pop);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= out_in;
      end
   end

endmodule

// ===== rtl/pcap_radiotap_record_framer.sv =====
`timescale 1ns / 1ps

// PCAP record framer with radiotap prefix.
// Input side: push/full queue of captured frame bytes (req_word), one per word.
//   A word with first_of_frame set also carries time, length, signal and
//   channel; it opens a record of a 16-byte PCAP header, a 15-byte radiotap
//   header and then up to min(snap_length, 256) payload bytes.
// Result side: empty/pop queue; rsp_word holds the oldest waiting byte while
//   empty is low, with record_last set on the final byte of each record.
// Config side: csr_valid/csr_ready write port, always ready; index 0 is
//   capture_enable, index 1 is snap_length. Write only while idle.
// Path: an accepted byte reaches rsp_word through three divider stages for
//   the seconds/microseconds split, the command queue and the output register.
// Throughput: one word per cycle in while full is low, one byte per cycle out
//   while the receiver pops; a first word expands to 31 or 32 output bytes, so
//   the 8-entry command queue can fill and raise full while the header drains.
// Reset: capture off, snap_length 256, no open record, both queues empty.
// A stalled receiver holds the output register; the queue keeps taking words
//   until it has no room left for the words in flight.
module pcap_radiotap_record_framer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  prf_pkg::req_type                req_word,
   output logic                            empty,
   input  logic                            pop,
   output prf_pkg::rsp_type                rsp_word,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [prf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [prf_pkg::SNAP_W-1:0]      csr_wdata
);

   logic                 cmd_push, deq;
   prf_pkg::cmd_type     cmd_word, head;
   prf_pkg::q_stat_type  q_stat;

   // Registers take a write every cycle
   assign csr_ready = 1'b1;

   // Classify words, track the record, split the timestamp
   prf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_word  (req_word),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_stat    (q_stat),
      .cmd_push  (cmd_push),
      .cmd_word  (cmd_word)
   );

   // Hold classified commands between the two sides
   prf_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_word (cmd_word),
      .rd_en   (deq),
      .rd_word (head),
      .q_stat  (q_stat)
   );

   // Expand each command into record bytes
   prf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_stat   (q_stat),
      .deq      (deq),
      .empty    (empty),
      .pop      (pop),
      .rsp_word (rsp_word)
   );

endmodule
